### hdl/fourth_order_state_space_filter_assert.svh
// assertion macros used by the filter checker
`ifndef FOURTH_ORDER_STATE_SPACE_FILTER_ASSERT_SVH
`define FOURTH_ORDER_STATE_SPACE_FILTER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define FOSSF_AST_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("filter check failed");

// next-cycle implication, disabled while in reset
`define FOSSF_AST_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("filter check failed");

`endif

### hdl/fossf_pkg.sv
// types, constants and register indexes of the state-space filter
package fossf_pkg;

	localparam int CoefW  = 16;
	localparam int StateW = 32;
	localparam int ProdW  = CoefW + StateW;
	localparam int AccW   = 52;
	localparam int StShift  = 13;
	localparam int OutShift = 7;

	localparam logic signed [AccW-1:0] StRound  = AccW'(4096);
	localparam logic signed [AccW-1:0] OutRound = AccW'(64);

	localparam logic signed [StateW-1:0] StMax = 32'sh7FFF_FFFF;
	localparam logic signed [StateW-1:0] StMin = 32'sh8000_0000;
	localparam logic signed [CoefW-1:0]  OutMax = 16'sh7FFF;
	localparam logic signed [CoefW-1:0]  OutMin = 16'sh8000;

	// row tag 0..3 are state rows, the last one is the output product
	localparam logic [2:0] RowOut = 3'd4;
	// term 0..3 multiply the state, the last term multiplies the input
	localparam logic [2:0] TermIn = 3'd4;

	// configuration register indexes
	localparam logic [2:0] RegARow0   = 3'd0;
	localparam logic [2:0] RegARow1   = 3'd1;
	localparam logic [2:0] RegARow2   = 3'd2;
	localparam logic [2:0] RegARow3   = 3'd3;
	localparam logic [2:0] RegBColumn = 3'd4;
	localparam logic [2:0] RegOutGain = 3'd5;

	// command codes
	localparam logic CmdFilter = 1'b0;
	localparam logic CmdClear  = 1'b1;

	typedef struct packed {
		logic              cmd;
		logic signed [15:0] sample_in;
	} in_t;

	typedef struct packed {
		logic signed [15:0] sample_out;
		logic              saturated;
	} out_t;

	// one operand pair issued to the multiply-accumulate unit
	typedef struct packed {
		logic                     issue;
		logic                     first;
		logic                     last;
		logic [2:0]               tag;
		logic signed [CoefW-1:0]  a;
		logic signed [StateW-1:0] b;
	} mac_req_t;

	// rounded and saturated sum of one row
	typedef struct packed {
		logic                     done;
		logic [2:0]               tag;
		logic signed [StateW-1:0] value;
		logic                     sat;
	} mac_rsp_t;

endpackage

### hdl/fossf_mac.sv
// shared 16x32 multiply-accumulate unit with rounding and saturation
module fossf_mac (
	input  logic                clk,
	input  logic                arst_n,
	input  fossf_pkg::mac_req_t req,
	output fossf_pkg::mac_rsp_t rsp
);

	logic signed [fossf_pkg::CoefW-1:0]  op_a;
	logic signed [fossf_pkg::StateW-1:0] op_b;
	logic signed [fossf_pkg::ProdW-1:0]  prod_s1;
	logic                                vld_s1;
	logic                                first_s1;
	logic                                last_s1;
	logic [2:0]                          tag_s1;
	logic signed [fossf_pkg::AccW-1:0]   prod_ext;
	logic signed [fossf_pkg::AccW-1:0]   acc_q;
	logic                                done_q;
	logic [2:0]                          tag_q;
	logic signed [fossf_pkg::AccW-1:0]   st_sum;
	logic signed [fossf_pkg::AccW-1:0]   st_sh;
	logic signed [fossf_pkg::AccW-1:0]   out_sum;
	logic signed [fossf_pkg::AccW-1:0]   out_sh;
	logic                                st_ok;
	logic                                out_ok;
	logic signed [fossf_pkg::StateW-1:0] st_val;
	logic signed [fossf_pkg::CoefW-1:0]  out_val;

	assign op_a = req.a;
	assign op_b = req.b;
	assign prod_ext = {{(fossf_pkg::AccW - fossf_pkg::ProdW){prod_s1[fossf_pkg::ProdW-1]}},
		prod_s1};

	// control pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= req.issue;
			done_q <= vld_s1 & last_s1;
		end
	end

	// multiply stage
	always_ff @(posedge clk) begin
		if (req.issue) begin
			prod_s1  <= op_a * op_b;
			first_s1 <= req.first;
			last_s1  <= req.last;
			tag_s1   <= req.tag;
		end
	end

	// accumulate stage
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			acc_q <= first_s1 ? prod_ext : acc_q + prod_ext;
			tag_q <= tag_s1;
		end
	end

	// state row: round half up from Q2.13 coefficients and clamp to 32 bits
	assign st_sum = acc_q + fossf_pkg::StRound;
	assign st_sh  = st_sum >>> fossf_pkg::StShift;
	assign st_ok  = (&st_sh[fossf_pkg::AccW-1:fossf_pkg::StateW-1])
		| ~(|st_sh[fossf_pkg::AccW-1:fossf_pkg::StateW-1]);
	assign st_val = st_ok ? st_sh[fossf_pkg::StateW-1:0]
		: (st_sh[fossf_pkg::AccW-1] ? fossf_pkg::StMin : fossf_pkg::StMax);

	// output product: round half up from Q8.7 gain and clamp to 16 bits
	assign out_sum = acc_q + fossf_pkg::OutRound;
	assign out_sh  = out_sum >>> fossf_pkg::OutShift;
	assign out_ok  = (&out_sh[fossf_pkg::AccW-1:fossf_pkg::CoefW-1])
		| ~(|out_sh[fossf_pkg::AccW-1:fossf_pkg::CoefW-1]);
	assign out_val = out_ok ? out_sh[fossf_pkg::CoefW-1:0]
		: (out_sh[fossf_pkg::AccW-1] ? fossf_pkg::OutMin : fossf_pkg::OutMax);

	// result select by row tag
	always_comb begin
		rsp.done = done_q;
		rsp.tag  = tag_q;
		if (tag_q == fossf_pkg::RowOut) begin
			rsp.value = {{(fossf_pkg::StateW - fossf_pkg::CoefW){out_val[fossf_pkg::CoefW-1]}},
				out_val};
			rsp.sat   = ~out_ok;
		end else begin
			rsp.value = st_val;
			rsp.sat   = ~st_ok;
		end
	end

endmodule

### hdl/fourth_order_state_space_filter.sv
// Fourth-order state-space filter: per sample, x' = A*x + B*sample_in on four
// signed 32-bit states, then sample_out = loop2_current * out_gain, rounded and
// saturated. All 21 products go through one shared 16x32 multiply-accumulate unit
// with a two-stage pipeline, one product per clock. A filter transaction issues
// its products, captures the output product and loads it into the output
// register once that is free; a clear transaction zeroes the state and loads a
// zero result. in_ready is high only while the sequencer is idle; a result may
// wait in the output register while the next input transaction is accepted. The
// configuration port is always ready and must only be written while idle.
module fourth_order_state_space_filter (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  fossf_pkg::in_t   in_item,
	output logic             out_valid,
	input  logic             out_ready,
	output fossf_pkg::out_t  out_item,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [2:0]       cfg_index,
	input  logic [63:0]      cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_WAIT,
		ST_FIN
	} state_t;

	state_t                              state_q;
	logic [63:0]                         a_row_q [4];
	logic [63:0]                         b_col_q;
	logic signed [15:0]                  gain_q;
	logic signed [fossf_pkg::StateW-1:0] x_q  [4];
	logic signed [fossf_pkg::StateW-1:0] nx_q [4];
	logic signed [15:0]                  vin_q;
	logic [2:0]                          row_q;
	logic [2:0]                          term_q;
	logic                                sat_q;
	fossf_pkg::out_t                     res_q;
	fossf_pkg::out_t                     out_q;
	logic                                out_valid_q;
	fossf_pkg::mac_req_t                 req;
	fossf_pkg::mac_rsp_t                 rsp;
	logic                                in_fire;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid & in_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				a_row_q[i] <= '0;
			end
			b_col_q <= '0;
			gain_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				fossf_pkg::RegARow0:   a_row_q[0] <= cfg_data;
				fossf_pkg::RegARow1:   a_row_q[1] <= cfg_data;
				fossf_pkg::RegARow2:   a_row_q[2] <= cfg_data;
				fossf_pkg::RegARow3:   a_row_q[3] <= cfg_data;
				fossf_pkg::RegBColumn: b_col_q    <= cfg_data;
				fossf_pkg::RegOutGain: gain_q     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// operand select for the shared unit
	always_comb begin
		req.issue = (state_q == ST_RUN);
		req.first = (term_q == 3'd0) | (row_q == fossf_pkg::RowOut);
		req.last  = (term_q == fossf_pkg::TermIn) | (row_q == fossf_pkg::RowOut);
		req.tag   = row_q;
		if (row_q == fossf_pkg::RowOut) begin
			req.a = gain_q;
			req.b = nx_q[1];
		end else if (term_q == fossf_pkg::TermIn) begin
			req.a = b_col_q[{row_q[1:0], 4'b0000} +: 16];
			req.b = {{(fossf_pkg::StateW - 16){vin_q[15]}}, vin_q};
		end else begin
			req.a = a_row_q[row_q[1:0]][{term_q[1:0], 4'b0000} +: 16];
			req.b = x_q[term_q[1:0]];
		end
	end

	fossf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// sequencer, state vector and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q       <= '0;
			term_q      <= '0;
			sat_q       <= 1'b0;
			vin_q       <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				x_q[i]  <= '0;
				nx_q[i] <= '0;
			end
		end else begin
			// result leaves unless the finish step reloads the register
			if (out_valid_q && out_ready && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (in_item.cmd == fossf_pkg::CmdClear) begin
							for (int i = 0; i < 4; i++) begin
								x_q[i] <= '0;
							end
							res_q   <= '0;
							state_q <= ST_FIN;
						end else begin
							vin_q   <= in_item.sample_in;
							row_q   <= '0;
							term_q  <= '0;
							sat_q   <= 1'b0;
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (row_q == fossf_pkg::RowOut) begin
						state_q <= ST_WAIT;
					end else if (term_q == fossf_pkg::TermIn) begin
						term_q <= '0;
						row_q  <= row_q + 3'd1;
					end else begin
						term_q <= term_q + 3'd1;
					end
				end
				ST_WAIT: begin
					if (rsp.done && rsp.tag == fossf_pkg::RowOut) begin
						res_q.sample_out <= rsp.value[15:0];
						res_q.saturated  <= sat_q | rsp.sat;
						for (int i = 0; i < 4; i++) begin
							x_q[i] <= nx_q[i];
						end
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// capture finished state rows
			if (rsp.done && rsp.tag != fossf_pkg::RowOut) begin
				nx_q[rsp.tag[1:0]] <= rsp.value;
				sat_q              <= sat_q | rsp.sat;
			end
		end
	end

endmodule

### hdl/fossf_checker.sv
// port-level checker for the state-space filter and its bind
`include "fourth_order_state_space_filter_assert.svh"

module fossf_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input fossf_pkg::out_t out_item,
	input logic            cfg_valid,
	input logic            cfg_ready
);

	// a result waiting on the output holds
	`FOSSF_AST_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))

	// one transaction at a time: input closes right after acceptance
	`FOSSF_AST_NEXT(a_in_busy, in_valid && in_ready, !in_ready)

	// no result appears in the cycle right after an input transaction
	`FOSSF_AST_NEXT(a_no_early_out, in_valid && in_ready, !$rose(out_valid))

	// configuration writes are never stalled
	`FOSSF_AST_IMPLY(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind fourth_order_state_space_filter fossf_checker u_fossf_checker (.*);
